// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/tswt_pkg.sv =====
package tswt_pkg;

  localparam logic KindSleep = 1'b0;
  localparam logic KindTick  = 1'b1;

  localparam logic [1:0] EvSleepOk = 2'd0;
  localparam logic [1:0] EvFull    = 2'd1;
  localparam logic [1:0] EvWoken   = 2'd2;
  localparam logic [1:0] EvNone    = 2'd3;

  localparam int MaxOut = 16;
  localparam int OutCntW = $clog2(MaxOut + 1);

  typedef struct packed {
    logic        kind;
    logic [31:0] now_time;
    logic [7:0]  thread_number;
    logic [30:0] sleep_delay;
    logic [7:0]  thread_priority;
    logic        cpu_idle;
  } req_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] woken_thread;
    logic [7:0] woken_priority;
    logic       yield_request;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  thread;
    logic [7:0]  prio;
    logic [31:0] wake_time;
  } entry_t;

  typedef struct packed {
    logic       found;
    logic [7:0] prio;
  } best_t;

endpackage

// ===== rtl/tswt_cmp.sv =====
module tswt_cmp (
  input  tswt_pkg::entry_t entry,
  input  logic [31:0]      now_time,
  input  logic             taken,
  input  tswt_pkg::best_t  best,
  output logic             hit
);
  import tswt_pkg::*;

  logic due;
  logic better;

  assign due    = (entry.wake_time <= now_time) && !taken;
  assign better = !best.found || (entry.prio > best.prio);
  assign hit    = due && better;

endmodule

// ===== rtl/timed_sleep_wakeup_table.sv =====
// Sleep table with priority-ordered wakeup.
// Channels: req (req_valid/req_ready, payload req) carries one sleep request or
// one timer tick per beat; rsp (rsp_valid/rsp_ready, payload rsp) returns the
// result beats, the final one of each request marked by last.
// A sleep request stores its entry in the next free slot and presents its one
// beat from the sleep state once the output register is free (sleep accepted,
// or rejected when full).
// A tick runs up to 16 selection passes over the stored entries through one
// shared compare unit and one memory read port, then a compaction sweep that
// closes the gaps in arrival order. Results leave highest priority first,
// equal priorities in arrival order; a tick with nothing due returns one beat
// with the none-woken code.
// req_ready is high only while no item is in work; an item may be accepted
// while its predecessor's last beat still waits in the output register.
// When rsp_ready is low, the sequencer holds at the next result until the
// output register frees up; nothing is dropped.
// Reset empties the table at once (fill count to zero); no clearing pass.
`include "assert_macros.svh"

module timed_sleep_wakeup_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tswt_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tswt_pkg::rsp_t  rsp
);
  import tswt_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StSleep   = 3'd1;
  localparam logic [2:0] StScan    = 3'd2;
  localparam logic [2:0] StEmit    = 3'd3;
  localparam logic [2:0] StFlush   = 3'd4;
  localparam logic [2:0] StCompact = 3'd5;

  logic [2:0]             st;
  req_t                   item;
  logic [CntW-1:0]        count;
  logic [CntW-1:0]        scan_idx;
  logic [CntW-1:0]        wr_ptr;
  logic [TABLE_DEPTH-1:0] taken;
  logic [OutCntW-1:0]     n_out;
  best_t                  best;
  logic [IdxW-1:0]        best_idx;
  logic [7:0]             best_thr;
  logic                   pend;
  logic [7:0]             pend_thr;
  logic [7:0]             pend_pri;

  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd_data;
  logic                   rd_en;
  logic                   rd_vld;
  logic [IdxW-1:0]        rd_idx;

  logic                   out_free;
  logic                   rsp_load;
  logic                   hit;
  logic [32:0]            wake_sum;
  entry_t                 new_entry;
  logic                   yld;
  logic                   full;
  logic                   sleep_beat;
  logic                   none_beat;

  assign req_ready = (st == StIdle);
  assign out_free  = !rsp_valid || rsp_ready;
  assign rd_en     = ((st == StScan) || (st == StCompact)) && (scan_idx < count);
  assign full      = (count == CntW'(TABLE_DEPTH));
  assign yld       = !item.cpu_idle;
  assign rsp_load  = out_free && ((st == StSleep) || (st == StFlush) ||
                                  ((st == StEmit) && (pend || !best.found)));

  assign wake_sum  = {1'b0, item.now_time} + {2'b00, item.sleep_delay};
  assign new_entry = '{thread:    item.thread_number,
                       prio:      item.thread_priority,
                       wake_time: wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0]};

  assign sleep_beat = rsp_valid && ((rsp.event_res == EvSleepOk) || (rsp.event_res == EvFull));
  assign none_beat  = rsp_valid && (rsp.event_res == EvNone);

  tswt_cmp u_cmp (
    .entry    (rd_data),
    .now_time (item.now_time),
    .taken    (taken[rd_idx]),
    .best     (best),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan_idx[IdxW-1:0]];
    end
    if ((st == StSleep) && out_free && !full) begin
      mem[count[IdxW-1:0]] <= new_entry;
    end else if ((st == StCompact) && rd_vld && !taken[rd_idx]) begin
      mem[wr_ptr[IdxW-1:0]] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= StIdle;
      count     <= '0;
      rsp_valid <= 1'b0;
      rd_vld    <= 1'b0;
      pend      <= 1'b0;
      best      <= '0;
      n_out     <= '0;
      scan_idx  <= '0;
      wr_ptr    <= '0;
      taken     <= '0;
    end else begin
      rd_vld <= rd_en;
      rd_idx <= scan_idx[IdxW-1:0];
      if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (st)
        StIdle: begin
          if (req_valid) begin
            item     <= req;
            scan_idx <= '0;
            best     <= '0;
            taken    <= '0;
            n_out    <= '0;
            pend     <= 1'b0;
            st       <= (req.kind == KindSleep) ? StSleep : StScan;
          end
        end
        StSleep: begin
          if (out_free) begin
            rsp <= '{event_res:      full ? EvFull : EvSleepOk,
                     woken_thread:   8'd0,
                     woken_priority: 8'd0,
                     yield_request:  1'b0,
                     last:           1'b1};
            if (!full) begin
              count <= count + 1'b1;
            end
            st <= StIdle;
          end
        end
        StScan: begin
          if (rd_vld && hit) begin
            best     <= '{found: 1'b1, prio: rd_data.prio};
            best_idx <= rd_idx;
            best_thr <= rd_data.thread;
          end
          if (!rd_en && !rd_vld) begin
            st <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            if (pend || !best.found) begin
              rsp <= '{event_res:      pend ? EvWoken : EvNone,
                       woken_thread:   pend ? pend_thr : 8'd0,
                       woken_priority: pend ? pend_pri : 8'd0,
                       yield_request:  yld,
                       last:           !best.found};
            end
            if (best.found) begin
              pend            <= 1'b1;
              pend_thr        <= best_thr;
              pend_pri        <= best.prio;
              taken[best_idx] <= 1'b1;
              n_out           <= n_out + 1'b1;
              best            <= '0;
              scan_idx        <= '0;
              st <= (n_out == OutCntW'(MaxOut - 1)) ? StFlush : StScan;
            end else begin
              scan_idx <= '0;
              wr_ptr   <= '0;
              st       <= StCompact;
            end
          end
        end
        StFlush: begin
          if (out_free) begin
            rsp <= '{event_res:      EvWoken,
                     woken_thread:   pend_thr,
                     woken_priority: pend_pri,
                     yield_request:  yld,
                     last:           1'b1};
            scan_idx <= '0;
            wr_ptr   <= '0;
            st       <= StCompact;
          end
        end
        StCompact: begin
          if (rd_vld && !taken[rd_idx]) begin
            wr_ptr <= wr_ptr + 1'b1;
          end
          if (!rd_en && !rd_vld) begin
            count <= wr_ptr;
            st    <= StIdle;
          end
        end
        default: begin
          st <= StIdle;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CntW'(TABLE_DEPTH), "fill count above depth")
  `ASSERT_ALWAYS(a_nout_bound, clk, rst, n_out <= OutCntW'(MaxOut), "too many wakeups in one tick")
  `ASSERT_IMPLY(a_sleep_last, clk, rst, sleep_beat, rsp.last && !rsp.yield_request, "sleep beat not single")
  `ASSERT_IMPLY(a_compact_order, clk, rst, st == StCompact, wr_ptr <= scan_idx, "compaction write passed read")
  `ASSERT_IMPLY(a_none_last, clk, rst, none_beat, rsp.last, "none-woken beat not final")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import tswt_pkg::*;

  localparam int TableDepth  = 16;
  localparam int RandomItems = 225;
  localparam int StallLimit  = 5000;

  typedef struct packed {
    logic [7:0]  thread;
    logic [7:0]  prio;
    logic [31:0] wake;
  } sleeper_t;

  typedef struct {
    bit   typed;
    rsp_t beat;
  } pinned_t;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t beat;
  } step_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  sleeper_t sleepers[$];
  rsp_t     due_beats[$];
  pinned_t  pinned_q[$];

  int          mismatches   = 0;
  int          sleeps_seen  = 0;
  int          ticks_seen   = 0;
  int          beats_seen   = 0;
  int          wakeups_seen = 0;
  int          full_seen    = 0;
  int          burst_left   = 0;
  int          quiet_cycles = 0;
  int          sink_count   = 0;
  int          sink_mode    = 0;
  logic [31:0] sink_pattern = '1;
  logic [31:0] clock_now    = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timed_sleep_wakeup_table #(.TABLE_DEPTH(TableDepth)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  function automatic rsp_t make_beat(logic [1:0] ev, logic [7:0] thr, logic [7:0] pri,
                                     logic yld, logic lst);
    rsp_t b;
    b.event_res      = ev;
    b.woken_thread   = thr;
    b.woken_priority = pri;
    b.yield_request  = yld;
    b.last           = lst;
    return b;
  endfunction

  function automatic req_t sleep_req(logic [31:0] now, logic [7:0] thr, logic [30:0] delay,
                                     logic [7:0] pri, logic idle);
    req_t r;
    r.kind            = KindSleep;
    r.now_time        = now;
    r.thread_number   = thr;
    r.sleep_delay     = delay;
    r.thread_priority = pri;
    r.cpu_idle        = idle;
    return r;
  endfunction

  // unused fields carry random junk
  function automatic req_t tick_req(logic [31:0] now, logic idle);
    req_t r;
    r.kind            = KindTick;
    r.now_time        = now;
    r.thread_number   = 8'($urandom);
    r.sleep_delay     = 31'($urandom);
    r.thread_priority = 8'($urandom);
    r.cpu_idle        = idle;
    return r;
  endfunction

  task automatic wake_table_step(input req_t r);
    sleeper_t    s;
    sleeper_t    keep[$];
    bit          taken[TableDepth];
    logic [32:0] sum;
    logic        yld;
    int          n;
    int          best;
    if (r.kind == KindSleep) begin
      sleeps_seen++;
      if (sleepers.size() >= TableDepth) begin
        due_beats.push_back(make_beat(EvFull, 8'h00, 8'h00, 1'b0, 1'b1));
      end else begin
        sum      = {1'b0, r.now_time} + {2'b00, r.sleep_delay};
        s.thread = r.thread_number;
        s.prio   = r.thread_priority;
        s.wake   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        sleepers.push_back(s);
        due_beats.push_back(make_beat(EvSleepOk, 8'h00, 8'h00, 1'b0, 1'b1));
      end
    end else begin
      ticks_seen++;
      yld = ~r.cpu_idle;
      n   = 0;
      for (int i = 0; i < TableDepth; i++) taken[i] = 1'b0;
      while (n < MaxOut) begin
        best = -1;
        for (int i = 0; i < sleepers.size(); i++) begin
          if (!taken[i] && sleepers[i].wake <= r.now_time) begin
            if (best < 0 || sleepers[i].prio > sleepers[best].prio) best = i;
          end
        end
        if (best < 0) break;
        taken[best] = 1'b1;
        due_beats.push_back(make_beat(EvWoken, sleepers[best].thread, sleepers[best].prio,
                                      yld, 1'b0));
        n++;
      end
      for (int i = 0; i < sleepers.size(); i++) begin
        if (!taken[i]) keep.push_back(sleepers[i]);
      end
      sleepers = keep;
      if (n == 0) begin
        due_beats.push_back(make_beat(EvNone, 8'h00, 8'h00, yld, 1'b1));
      end else begin
        due_beats[due_beats.size() - 1].last = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_beat(input rsp_t got, input rsp_t want);
    if (got.event_res !== want.event_res)
      report_mismatch($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
    if (got.woken_thread !== want.woken_thread)
      report_mismatch($sformatf("woken_thread got %02h want %02h",
                                got.woken_thread, want.woken_thread));
    if (got.woken_priority !== want.woken_priority)
      report_mismatch($sformatf("woken_priority got %02h want %02h",
                                got.woken_priority, want.woken_priority));
    if (got.yield_request !== want.yield_request)
      report_mismatch($sformatf("yield_request got %b want %b",
                                got.yield_request, want.yield_request));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %b want %b", got.last, want.last));
  endtask

  always @(posedge clk) begin : monitor
    pinned_t pin;
    if (!rst) begin
      if (req_valid && req_ready) begin
        pin = pinned_q.pop_front();
        wake_table_step(req);
        if (pin.typed) begin
          void'(due_beats.pop_back());
          due_beats.push_back(pin.beat);
        end
      end
      if (rsp_valid && rsp_ready) begin
        beats_seen++;
        if (rsp.event_res == EvWoken) wakeups_seen++;
        if (rsp.event_res == EvFull) full_seen++;
        if (due_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, event_res %0d", rsp.event_res));
        end else begin
          check_beat(rsp, due_beats.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin : sink
    if (sink_count == 0) begin
      sink_mode    = $urandom_range(0, 3);
      sink_pattern = $urandom;
    end
    sink_count = (sink_count + 1) % 64;
    case (sink_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= 1'($urandom_range(0, 1));
      2: rsp_ready <= sink_pattern[sink_count % 32];
      default: rsp_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d still due", StallLimit, due_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input req_t item, input bit typed, input rsp_t beat);
    pinned_q.push_back('{typed, beat});
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // hold valid through a burst, drop it for a random gap between bursts
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap        = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic req_t random_item();
    int          pick;
    int          span;
    logic [30:0] delay;
    logic [7:0]  pri;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      span = $urandom_range(0, 99);
      if (span < 70) delay = 31'($urandom_range(0, 40));
      else if (span < 85) delay = 31'($urandom_range(0, 1000));
      else if (span < 95) delay = 31'($urandom);
      else delay = 31'h7FFF_FFFF;
      pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      now = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_now;
      return sleep_req(now, 8'($urandom), delay, pri, 1'($urandom_range(0, 1)));
    end
    clock_now = clock_now + $urandom_range(0, 25);
    span      = $urandom_range(0, 99);
    if (span < 4) now = 32'hFFFF_FFFF;
    else if (span < 7) now = $urandom;
    else now = clock_now;
    return tick_req(now, 1'($urandom_range(0, 1)));
  endfunction

  initial begin : driver
    step_t plan[$];
    rsp_t  ok_beat;
    rsp_t  none_beat;
    ok_beat   = make_beat(EvSleepOk, 8'h00, 8'h00, 1'b0, 1'b1);
    none_beat = make_beat(EvNone, 8'h00, 8'h00, 1'b0, 1'b1);

    plan.push_back('{tick_req(32'h0000_0000, 1'b0), 1'b1,
                     make_beat(EvNone, 8'h00, 8'h00, 1'b1, 1'b1)});
    plan.push_back('{tick_req(32'hFFFF_FFFF, 1'b1), 1'b1, none_beat});
    plan.push_back('{sleep_req(32'h0000_0000, 8'hFF, 31'h0, 8'hFF, 1'b1), 1'b1, ok_beat});
    plan.push_back('{sleep_req(32'hFFFF_FFFF, 8'h00, 31'h7FFF_FFFF, 8'h00, 1'b0), 1'b1, ok_beat});
    plan.push_back('{sleep_req(32'd100, 8'h12, 31'd10, 8'd5, 1'b0), 1'b1, ok_beat});
    plan.push_back('{sleep_req(32'd100, 8'h13, 31'd5, 8'd5, 1'b1), 1'b1, ok_beat});
    plan.push_back('{sleep_req(32'd100, 8'h14, 31'd20, 8'd9, 1'b0), 1'b1, ok_beat});
    plan.push_back('{tick_req(32'd104, 1'b0), 1'b0, ok_beat});
    plan.push_back('{tick_req(32'd110, 1'b1), 1'b0, ok_beat});
    for (int k = 0; k < 14; k++) begin
      plan.push_back('{sleep_req(32'd200, 8'h20 + 8'(k), 31'(k * 3), 8'((k % 4) * 60), 1'b0),
                       1'b1, ok_beat});
    end
    plan.push_back('{sleep_req(32'd200, 8'h40, 31'd1, 8'd1, 1'b0), 1'b1,
                     make_beat(EvFull, 8'h00, 8'h00, 1'b0, 1'b1)});
    plan.push_back('{tick_req(32'hFFFF_FFFF, 1'b0), 1'b0, ok_beat});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      send_item(plan[k].item, plan[k].typed, plan[k].beat);
      pace();
    end

    clock_now = $urandom_range(0, 1000);
    for (int k = 0; k < RandomItems; k++) begin
      send_item(random_item(), 1'b0, ok_beat);
      pace();
    end

    req_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("stimulus: %0d sleep requests and %0d ticks, %0d of them directed",
             sleeps_seen, ticks_seen, plan.size());
    $display("results: %0d beats checked, %0d wakeups, %0d rejected as full, %0d mismatches",
             beats_seen, wakeups_seen, full_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
